[design/trwb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, command constants and BCD helpers for the three-wire RTC burst master.
package trwb_pkg;

    // Number of time bytes moved in one burst.
    localparam int unsigned NUM_TIME = 7;

    // Request kinds carried on the input side.
    localparam logic [1:0] REQ_TICK = 2'd0;

    // Command and control bytes sent on the wire.
    localparam logic [7:0] CMD_CTRL_WRITE  = 8'h8E;
    localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
    localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
    localparam logic [7:0] CTRL_PROTECT    = 8'h80;
    localparam logic [7:0] CTRL_OPEN       = 8'h00;
    localparam logic [7:0] HALF_PERIOD_MIN = 8'h01;

    // Operation in progress; the codes match the request kinds.
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_INIT  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // One result beat as produced by the engine.
    typedef struct packed {
        logic                          busy_res;
        logic [NUM_TIME-1:0][7:0]      time_bin;
        logic                          dio_out;
        logic                          chip_enable;
        logic                          sclk;
        logic                          done_res;
    } result_t;

    // Transactions in one request.
    function automatic logic [1:0] steps_of(input op_t op);
        logic [1:0] n;
        if (op == OP_INIT) begin
            n = 2'd2;
        end else if (op == OP_WRITE) begin
            n = 2'd3;
        end else begin
            n = 2'd1;
        end
        return n;
    endfunction

    // Bytes in one transaction.
    function automatic logic [3:0] bytes_of(input op_t op, input logic [1:0] step);
        logic [3:0] n;
        if (op == OP_WRITE && step == 2'd1) begin
            n = 4'd9;
        end else if (op == OP_READ) begin
            n = 4'd8;
        end else begin
            n = 4'd2;
        end
        return n;
    endfunction

    // Every byte of a burst read after the command byte is shifted in.
    function automatic logic is_read_byte(input op_t op, input logic [3:0] idx);
        return (op == OP_READ) && (idx != 4'd0);
    endfunction

    // Binary to BCD for values below 100; tens come from a reciprocal multiply, exact below 128.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [3:0]  units;
        prod     = 15'(v) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
        units    = 4'(v - tens_x10);
        return {tens, units};
    endfunction

    // BCD to binary without masking the digits, so the result stays below 166.
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

endpackage

[design/trwb_engine.sv]
`timescale 1ns / 1ps
// Serial sequencer state, its next-state logic and the result it produces for each tick.
module trwb_engine
    import trwb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        tick_accept,
    input  logic [1:0]  req_type,
    input  logic        dio_in,
    input  logic [6:0]  time_in [NUM_TIME],
    output result_t     result
);

    logic [7:0] hp_reg;
    op_t        op_reg, op_next;
    logic [1:0] step_reg, step_next;
    logic [3:0] byte_reg, byte_next;
    logic [2:0] bit_reg, bit_next;
    logic       phase_reg, phase_next;
    logic [7:0] div_reg, div_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] time_reg [NUM_TIME];
    logic [7:0] time_next [NUM_TIME];
    logic       done_next;

    logic [7:0] hp_eff;
    logic [7:0] div_inc;
    logic       half_end;
    logic [3:0] nbytes_cur;
    logic [3:0] byte_inc;
    logic [1:0] step_inc;
    logic       rd_cur;
    logic [2:0] rd_idx;
    logic [2:0] send_idx;
    logic [7:0] send_byte;
    logic [3:0] nbytes_nx;
    logic       on_wire;

    // Half period register; zero behaves as one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg <= HALF_PERIOD_MIN;
        end else if (cfg_we) begin
            hp_reg <= cfg_wdata;
        end
    end

    assign hp_eff     = (hp_reg == 8'd0) ? HALF_PERIOD_MIN : hp_reg;
    assign div_inc    = div_reg + 8'd1;
    assign half_end   = (div_inc >= hp_eff);
    assign nbytes_cur = bytes_of(op_reg, step_reg);
    assign byte_inc   = byte_reg + 4'd1;
    assign step_inc   = step_reg + 2'd1;
    assign rd_cur     = is_read_byte(op_reg, byte_reg);
    assign rd_idx     = 3'(byte_reg - 4'd1);
    assign send_idx   = 3'(byte_inc - 4'd1);

    // Byte that goes out next once the current byte has finished.
    always_comb begin
        if (op_reg == OP_READ) begin
            send_byte = (byte_inc == 4'd0) ? CMD_BURST_READ : CTRL_OPEN;
        end else if (op_reg == OP_WRITE && step_reg == 2'd1) begin
            if (byte_inc == 4'd0) begin
                send_byte = CMD_BURST_WRITE;
            end else if (byte_inc <= 4'(NUM_TIME)) begin
                send_byte = time_reg[send_idx];
            end else begin
                send_byte = CTRL_OPEN;
            end
        end else if (byte_inc == 4'd0) begin
            send_byte = CMD_CTRL_WRITE;
        end else if ((op_reg == OP_INIT && step_reg == 2'd1) ||
                     (op_reg == OP_WRITE && step_reg == 2'd2)) begin
            send_byte = CTRL_PROTECT;
        end else begin
            send_byte = CTRL_OPEN;
        end
    end

    // Next state for one tick.
    always_comb begin
        op_next    = op_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        div_next   = div_reg;
        shift_next = shift_reg;
        time_next  = time_reg;
        done_next  = 1'b0;
        if (op_reg == OP_IDLE) begin
            if (req_type != REQ_TICK) begin
                op_next    = op_t'(req_type);
                step_next  = 2'd0;
                byte_next  = 4'd0;
                bit_next   = 3'd0;
                phase_next = 1'b0;
                div_next   = 8'd0;
                shift_next = (op_t'(req_type) == OP_READ) ? CMD_BURST_READ : CMD_CTRL_WRITE;
                if (op_t'(req_type) == OP_WRITE) begin
                    for (int i = 0; i < NUM_TIME; i++) begin
                        time_next[i] = to_bcd(time_in[i]);
                    end
                end
            end
        end else begin
            div_next = div_inc;
            if (half_end) begin
                div_next = 8'd0;
                if (byte_reg >= nbytes_cur) begin
                    // Release half period is over: next transaction or finish.
                    if (step_inc >= steps_of(op_reg)) begin
                        op_next    = OP_IDLE;
                        step_next  = 2'd0;
                        byte_next  = 4'd0;
                        bit_next   = 3'd0;
                        phase_next = 1'b0;
                        shift_next = 8'd0;
                        done_next  = 1'b1;
                    end else begin
                        step_next  = step_inc;
                        byte_next  = 4'd0;
                        bit_next   = 3'd0;
                        phase_next = 1'b0;
                        shift_next = (op_reg == OP_WRITE && step_inc == 2'd1) ?
                                     CMD_BURST_WRITE : CMD_CTRL_WRITE;
                    end
                end else if (!phase_reg) begin
                    // End of the low half: sample the pin on read bytes.
                    if (rd_cur) begin
                        shift_next = {dio_in, shift_reg[7:1]};
                    end
                    phase_next = 1'b1;
                end else begin
                    // End of the high half: advance to the next bit.
                    phase_next = 1'b0;
                    if (!rd_cur) begin
                        shift_next = {1'b0, shift_reg[7:1]};
                    end
                    if (bit_reg == 3'd7) begin
                        if (rd_cur) begin
                            time_next[rd_idx] = shift_reg;
                        end
                        bit_next   = 3'd0;
                        byte_next  = byte_inc;
                        shift_next = (byte_inc < nbytes_cur) ? send_byte : CTRL_OPEN;
                    end else begin
                        bit_next = bit_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Pin levels and read-back values as they stand after the tick.
    assign nbytes_nx = bytes_of(op_next, step_next);
    assign on_wire   = (op_next != OP_IDLE) && (byte_next < nbytes_nx);

    always_comb begin
        result.done_res    = done_next;
        result.busy_res    = (op_next != OP_IDLE);
        result.chip_enable = on_wire;
        result.sclk        = on_wire ? phase_next : 1'b1;
        if (on_wire && !is_read_byte(op_next, byte_next)) begin
            result.dio_out = shift_next[0];
        end else begin
            result.dio_out = 1'b1;
        end
        for (int i = 0; i < NUM_TIME; i++) begin
            result.time_bin[i] = from_bcd(time_next[i]);
        end
    end

    // State advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= OP_IDLE;
            step_reg  <= 2'd0;
            byte_reg  <= 4'd0;
            bit_reg   <= 3'd0;
            phase_reg <= 1'b0;
            div_reg   <= 8'd0;
            shift_reg <= 8'd0;
            for (int i = 0; i < NUM_TIME; i++) begin
                time_reg[i] <= 8'd0;
            end
        end else if (tick_accept) begin
            op_reg    <= op_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
            bit_reg   <= bit_next;
            phase_reg <= phase_next;
            div_reg   <= div_next;
            shift_reg <= shift_next;
            time_reg  <= time_next;
        end
    end

endmodule

[design/trwb_out_buf.sv]
`timescale 1ns / 1ps
// Result register with a skid stage, so a new beat can enter while one waits.
module trwb_out_buf
    import trwb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop        = main_valid_reg && m_ready;
    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_reg;

    // Valid flags: the skid beat always drains into the main register first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

[design/three_wire_rtc_burst_master.sv]
`timescale 1ns / 1ps
// Top level of the three-wire RTC burst master: beat unpacking, engine and result buffer.
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------------
//  cfg     | in        | cfg_wdata: half period in ticks, written when cfg_we is high
//  s_      | in        | one tick: request kind in tuser, pin sample and time in tdata
//  m_      | out       | pin levels, read-back time and busy in tdata, done in tlast
//
// Every accepted input beat is one tick and yields one result beat, registered in the
// result buffer; a beat can be taken every cycle while s_tready is high. Synchronous
// active-low reset returns the sequencer to idle with the time store cleared and the
// half period set to one tick. When the result side stalls, a skid stage holds one
// extra beat; s_tready drops only once it is full.
module three_wire_rtc_burst_master
    import trwb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // dio_in[0], sec_in[6:1], min_in[12:7], hour_in[17:13], date_in[22:18],
    // month_in[26:23], weekday_in[29:27], year_in[36:30], zero fill above
    input  logic [39:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sclk[0], chip_enable[1], dio_out[2], sec_out[10:3], min_out[18:11],
    // hour_out[26:19], date_out[34:27], month_out[42:35], weekday_out[50:43],
    // year_out[58:51], busy_res[59], zero fill above
    output logic [63:0] m_tdata,
    output logic        m_tlast
);

    logic       tick_accept;
    logic [6:0] time_in [NUM_TIME];
    result_t    eng_result;
    result_t    out_result;

    assign tick_accept = s_tvalid && s_tready;

    // Time fields widened to a common width, seconds first.
    assign time_in[0] = {1'b0, s_tdata[6:1]};
    assign time_in[1] = {1'b0, s_tdata[12:7]};
    assign time_in[2] = {2'b00, s_tdata[17:13]};
    assign time_in[3] = {2'b00, s_tdata[22:18]};
    assign time_in[4] = {3'b000, s_tdata[26:23]};
    assign time_in[5] = {4'b0000, s_tdata[29:27]};
    assign time_in[6] = s_tdata[36:30];

    trwb_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .tick_accept (tick_accept),
        .req_type    (s_tuser),
        .dio_in      (s_tdata[0]),
        .time_in     (time_in),
        .result      (eng_result)
    );

    trwb_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (tick_accept),
        .push_data  (eng_result),
        .push_ready (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (out_result)
    );

    // Result beat packing.
    assign m_tdata = {4'b0000, out_result.busy_res, out_result.time_bin,
                      out_result.dio_out, out_result.chip_enable, out_result.sclk};
    assign m_tlast = out_result.done_res;

`ifndef NO_ASSERTIONS
    // Input side only stalls while a result is held.
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    // Chip enable on the wire only during a request.
    a_ce_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[59])
        else $error("chip enable high outside a request");

    // A finished request leaves the bus released and idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (!m_tdata[59] && m_tdata[0] && !m_tdata[1] && m_tdata[2]))
        else $error("done beat without released bus");
`endif

endmodule
